// ===== hdl/event_credit_pool_controller_defines.svh =====
// Assertion macros shared by the credit pool controller RTL.
`ifndef EVENT_CREDIT_POOL_CONTROLLER_DEFINES_SVH
`define EVENT_CREDIT_POOL_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ECPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecpc assertion failed");

// Next-cycle implication, disabled during reset.
`define ECPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecpc assertion failed");

`else

`define ECPC_ASSERT_NOW(label, clk, rst, ante, cons)
`define ECPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/ecpc_pkg.sv =====
// Types, codes and reset values for the event credit pool controller.
package ecpc_pkg;

  localparam int PORT_IDX_W     = 6;
  localparam int COUNT_W        = 8;
  localparam int CREDIT_W       = 16;
  localparam int MIN_W          = 11;
  localparam int MAX_W          = 13;
  localparam int DEF_PORT_COUNT = 64;

  // opcodes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RETURN  = 1'b1;

  // deny causes
  localparam logic [1:0] CAUSE_NONE      = 2'd0;
  localparam logic [1:0] CAUSE_THRESHOLD = 2'd1;
  localparam logic [1:0] CAUSE_EXHAUSTED = 2'd2;

  // register indexes
  localparam logic [1:0] REG_LOAN_LIMIT  = 2'd0;
  localparam logic [1:0] REG_NEW_EVT_THR = 2'd1;
  localparam logic [1:0] REG_PORT_MIN    = 2'd2;
  localparam logic [1:0] REG_PORT_MAX    = 2'd3;

  localparam logic [CREDIT_W-1:0] RST_LOAN_LIMIT  = 16'd4096;
  localparam logic [CREDIT_W-1:0] RST_NEW_EVT_THR = 16'd4096;
  localparam logic [MIN_W-1:0]    RST_PORT_MIN    = 11'd64;
  localparam logic [MAX_W-1:0]    RST_PORT_MAX    = 13'd512;

  typedef struct packed {
    logic                  opcode;
    logic [PORT_IDX_W-1:0] port_index;
    logic [COUNT_W-1:0]    credit_count;
    logic [COUNT_W-1:0]    new_count;
  } req_item_t;

  typedef struct packed {
    logic                granted;
    logic [COUNT_W-1:0]  accepted_count;
    logic [1:0]          deny_cause;
    logic [CREDIT_W-1:0] pool_on_loan;
  } rsp_item_t;

  typedef struct packed {
    logic [CREDIT_W-1:0] loan_limit;
    logic [CREDIT_W-1:0] new_evt_thr;
    logic [MIN_W-1:0]    port_min_credits;
    logic [MAX_W-1:0]    port_max_credits;
  } cfg_t;

  // state written back after one item
  typedef struct packed {
    logic [CREDIT_W-1:0] cache;
    logic [CREDIT_W-1:0] pool;
  } state_upd_t;

endpackage

// ===== hdl/ecpc_cfg_regs.sv =====
// APB configuration registers of the credit pool controller.
module ecpc_cfg_regs
  import ecpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loan_limit       <= RST_LOAN_LIMIT;
      cfg.new_evt_thr      <= RST_NEW_EVT_THR;
      cfg.port_min_credits <= RST_PORT_MIN;
      cfg.port_max_credits <= RST_PORT_MAX;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOAN_LIMIT:  cfg.loan_limit       <= pwdata[CREDIT_W-1:0];
        REG_NEW_EVT_THR: cfg.new_evt_thr      <= pwdata[CREDIT_W-1:0];
        REG_PORT_MIN:    cfg.port_min_credits <= pwdata[MIN_W-1:0];
        REG_PORT_MAX:    cfg.port_max_credits <= pwdata[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOAN_LIMIT:  prdata = 32'(cfg.loan_limit);
      REG_NEW_EVT_THR: prdata = 32'(cfg.new_evt_thr);
      REG_PORT_MIN:    prdata = 32'(cfg.port_min_credits);
      REG_PORT_MAX:    prdata = 32'(cfg.port_max_credits);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== hdl/ecpc_cache_mem.sv =====
// Per-port credit cache: memory with valid bits and write-to-read bypass.
module ecpc_cache_mem
  import ecpc_pkg::*;
#(
  parameter int PORT_COUNT = DEF_PORT_COUNT,
  parameter int AW         = PORT_IDX_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [CREDIT_W-1:0] wr_data,
  output logic [CREDIT_W-1:0] rd_data
);

  logic [CREDIT_W-1:0]   mem [PORT_COUNT];
  logic [PORT_COUNT-1:0] valid;
  logic [CREDIT_W-1:0]   mem_q;
  logic                  valid_q;
  logic                  byp_q;
  logic [CREDIT_W-1:0]   byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
        byp_q   <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data = byp_q ? byp_data : (valid_q ? mem_q : '0);

endmodule

// ===== hdl/ecpc_core.sv =====
// Credit decision for one item: acquire or return against cache and pool.
module ecpc_core
  import ecpc_pkg::*;
(
  input  cfg_t                cfg,
  input  req_item_t           item,
  input  logic [CREDIT_W-1:0] cache,
  input  logic [CREDIT_W-1:0] pool,
  output rsp_item_t           result,
  output state_upd_t          upd
);

  logic [CREDIT_W:0]   ret_sum;
  logic                ret_over;
  logic signed [18:0]  ret_back;
  logic signed [18:0]  ret_pool;
  logic [CREDIT_W-1:0] ret_pool_sat;
  logic                thr_deny;
  logic                from_cache;
  logic [COUNT_W-1:0]  missing;
  logic [MIN_W-1:0]    take;
  logic                exhausted;

  always_comb begin
    // return path
    ret_sum  = {1'b0, cache} + (CREDIT_W+1)'(item.credit_count);
    ret_over = ret_sum > (CREDIT_W+1)'(cfg.port_max_credits);
    ret_back = signed'(19'(ret_sum)) - signed'(19'(cfg.port_min_credits));
    ret_pool = signed'(19'(pool)) - ret_back;
    if (ret_pool < 0) begin
      ret_pool_sat = '0;
    end else if (ret_pool > 19'sd65535) begin
      ret_pool_sat = '1;
    end else begin
      ret_pool_sat = ret_pool[CREDIT_W-1:0];
    end

    // acquire path
    thr_deny   = (item.new_count != '0) && (pool > cfg.new_evt_thr);
    from_cache = CREDIT_W'(item.credit_count) <= cache;
    missing    = item.credit_count - cache[COUNT_W-1:0];
    take       = (MIN_W'(missing) > cfg.port_min_credits) ? MIN_W'(missing)
                                                           : cfg.port_min_credits;
    exhausted  = ((CREDIT_W+1)'(pool) + (CREDIT_W+1)'(take))
                 > (CREDIT_W+1)'(cfg.loan_limit);

    result.granted        = 1'b1;
    result.accepted_count = item.credit_count;
    result.deny_cause     = CAUSE_NONE;
    upd.cache             = cache;
    upd.pool              = pool;

    if (item.opcode == OP_RETURN) begin
      if (ret_over) begin
        upd.cache = CREDIT_W'(cfg.port_min_credits);
        upd.pool  = ret_pool_sat;
      end else begin
        upd.cache = ret_sum[CREDIT_W] ? '1 : ret_sum[CREDIT_W-1:0];
      end
    end else if (thr_deny) begin
      result.granted        = 1'b0;
      result.accepted_count = '0;
      result.deny_cause     = CAUSE_THRESHOLD;
    end else if (from_cache) begin
      upd.cache = cache - CREDIT_W'(item.credit_count);
    end else if (exhausted) begin
      result.granted        = 1'b0;
      result.accepted_count = '0;
      result.deny_cause     = CAUSE_EXHAUSTED;
    end else begin
      // pool + take stays within the loan limit, no saturation needed
      upd.pool  = pool + CREDIT_W'(take);
      upd.cache = cache + CREDIT_W'(take) - CREDIT_W'(item.credit_count);
    end

    result.pool_on_loan = upd.pool;
  end

endmodule

// ===== hdl/event_credit_pool_controller.sv =====
// Event credit pool controller: top level with request and result stages.
//
// Request channel (req_valid/req_stall/req) carries acquire or return items
// naming a port. Each accepted item yields exactly one result item on the
// result channel (rsp_valid/rsp_stall/rsp): granted flag, accepted count,
// deny cause and the pool loan after the item.
// The port's cached credits are read from the cache memory at acceptance, and
// the decision runs between that read register and the result register.
// One item per cycle is sustained unless rsp_stall holds a result; the cache
// read-modify-write is closed by a bypass from the write port.
// When rsp_stall holds a result, the decision stage keeps its item and
// req_stall rises only once that stage is also occupied.
// Reset clears the pool loan, the pipeline and the cache valid bits, so all
// ports start with zero cached credits; registers return to defaults. The user
// must write registers over APB only while no item is in flight; not enforced.
`include "event_credit_pool_controller_defines.svh"

module event_credit_pool_controller
  import ecpc_pkg::*;
#(
  parameter int PORT_COUNT = DEF_PORT_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_item_t   req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW         = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int PORT_CODES = 1 << PORT_IDX_W;

  cfg_t                cfg;
  logic [AW-1:0]       port_lut [PORT_CODES];
  logic                accept;
  logic                s1_vld;
  logic                s1_adv;
  req_item_t           s1_item;
  logic [AW-1:0]       s1_addr;
  logic [CREDIT_W-1:0] cache_rd;
  logic [CREDIT_W-1:0] pool;
  rsp_item_t           result;
  state_upd_t          upd;

  // port index modulo the port count as a constant table
  for (genvar i = 0; i < PORT_CODES; i++) begin : g_port_lut
    assign port_lut[i] = AW'(i % PORT_COUNT);
  end

  ecpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_adv    = s1_vld && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_vld && !s1_adv;
  assign accept    = req_valid && !req_stall;

  ecpc_cache_mem #(
    .PORT_COUNT (PORT_COUNT),
    .AW         (AW)
  ) u_cache (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (port_lut[req.port_index]),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (upd.cache),
    .rd_data (cache_rd)
  );

  ecpc_core u_core (
    .cfg    (cfg),
    .item   (s1_item),
    .cache  (cache_rd),
    .pool   (pool),
    .result (result),
    .upd    (upd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= req;
      s1_addr <= port_lut[req.port_index];
    end
    if (s1_adv) begin
      rsp <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      rsp_valid <= 1'b0;
      pool      <= '0;
    end else begin
      if (accept) begin
        s1_vld <= 1'b1;
      end else if (s1_adv) begin
        s1_vld <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid <= 1'b1;
        pool      <= upd.pool;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ECPC_ASSERT_NOW(a_empty_no_stall, clk, rst, !s1_vld, !req_stall)
  `ECPC_ASSERT_NEXT(a_adv_loads_rsp, clk, rst, s1_adv, rsp_valid)
  `ECPC_ASSERT_NEXT(a_deny_keeps_pool, clk, rst, s1_adv && !result.granted, $stable(pool))
  `ECPC_ASSERT_NEXT(a_acquire_no_drop, clk, rst, s1_adv && (s1_item.opcode == OP_ACQUIRE), pool >= $past(pool))

endmodule

// ===== test/ecpc_checker.sv =====
// Checker for the credit pool controller: predicts each result and compares it.
`timescale 1ns / 1ps

module ecpc_checker
  import ecpc_pkg::*;
#(
  parameter int PORT_COUNT = DEF_PORT_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_item_t   req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_results
);

  logic [CREDIT_W-1:0] lim_inflight;
  logic [CREDIT_W-1:0] lim_new_thr;
  logic [MIN_W-1:0]    lim_port_min;
  logic [MAX_W-1:0]    lim_port_max;

  logic [CREDIT_W-1:0] port_credit [PORT_COUNT];
  logic [CREDIT_W-1:0] pool_loan;

  rsp_item_t expected_results[$];

  function automatic logic [CREDIT_W-1:0] clamp16(longint v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return v[CREDIT_W-1:0];
  endfunction

  // Applies one item to the credit state and returns the result it should yield.
  function automatic rsp_item_t settle_credit(req_item_t r);
    int     p;
    longint cached;
    longint cnt;
    longint back;
    longint missing;
    longint take;
    longint avail;
    rsp_item_t res;
    p = int'(r.port_index) % PORT_COUNT;
    cached = longint'(port_credit[p]);
    cnt = longint'(r.credit_count);
    res.granted = 1'b1;
    res.accepted_count = r.credit_count;
    res.deny_cause = CAUSE_NONE;
    if (r.opcode == OP_RETURN) begin
      cached = cached + cnt;
      if (cached > longint'(lim_port_max)) begin
        // trim to the minimum; a minimum above the cache level borrows instead
        back = cached - longint'(lim_port_min);
        cached = longint'(lim_port_min);
        pool_loan = clamp16(longint'(pool_loan) - back);
      end
      port_credit[p] = clamp16(cached);
    end else if (r.new_count != 0 && pool_loan > lim_new_thr) begin
      res.granted = 1'b0;
      res.accepted_count = '0;
      res.deny_cause = CAUSE_THRESHOLD;
    end else if (cnt <= cached) begin
      port_credit[p] = clamp16(cached - cnt);
    end else begin
      missing = cnt - cached;
      take = (missing > longint'(lim_port_min)) ? missing : longint'(lim_port_min);
      avail = longint'(lim_inflight) - longint'(pool_loan);
      if (avail < take) begin
        res.granted = 1'b0;
        res.accepted_count = '0;
        res.deny_cause = CAUSE_EXHAUSTED;
      end else begin
        pool_loan = clamp16(longint'(pool_loan) + take);
        port_credit[p] = clamp16(cached + take - cnt);
      end
    end
    res.pool_on_loan = pool_loan;
    return res;
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      lim_inflight = RST_LOAN_LIMIT;
      lim_new_thr  = RST_NEW_EVT_THR;
      lim_port_min = RST_PORT_MIN;
      lim_port_max = RST_PORT_MAX;
      foreach (port_credit[i]) port_credit[i] = '0;
      pool_loan = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result item with nothing outstanding: %p", $realtime, rsp);
        end else begin
          want = expected_results.pop_front();
          check_field("granted", want.granted, rsp.granted);
          check_field("accepted_count", want.accepted_count, rsp.accepted_count);
          check_field("deny_cause", want.deny_cause, rsp.deny_cause);
          check_field("pool_on_loan", want.pool_on_loan, rsp.pool_on_loan);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LOAN_LIMIT:  lim_inflight = pwdata[CREDIT_W-1:0];
          REG_NEW_EVT_THR: lim_new_thr  = pwdata[CREDIT_W-1:0];
          REG_PORT_MIN:    lim_port_min = pwdata[MIN_W-1:0];
          REG_PORT_MAX:    lim_port_max = pwdata[MAX_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        expected_results.push_back(settle_credit(req));
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== test/event_credit_pool_controller_tb.sv =====
// Testbench top for the credit pool controller: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module event_credit_pool_controller_tb;
  import ecpc_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 228;
  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_item_t   req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_item_t   rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_results;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  cfg_t phase_cfg [PHASES];

  event_credit_pool_controller i_dut (.*);

  ecpc_checker i_chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // no item moving on either side for too long means the block is hung
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_item_t make_req(logic op, int port, int cnt, int newc);
    req_item_t r;
    r.opcode = op;
    r.port_index = port[PORT_IDX_W-1:0];
    r.credit_count = cnt[COUNT_W-1:0];
    r.new_count = newc[COUNT_W-1:0];
    return r;
  endfunction

  // Hot ports get most of the traffic so caches fill, trim and borrow.
  function automatic req_item_t random_req();
    int port;
    int cnt;
    int newc;
    port = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(63);
    cnt = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(128);
    if ($urandom_range(2) == 0)
      newc = 0;
    else
      newc = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(128);
    return make_req(($urandom_range(99) < 55) ? OP_ACQUIRE : OP_RETURN, port, cnt, newc);
  endfunction

  task automatic send_req(input req_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Hold the sender until every outstanding item has its result.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    phase_cfg[0] = cfg_t'{16'd4096,  16'd4096,  11'd64,   13'd512};
    phase_cfg[1] = cfg_t'{16'd300,   16'd100,   11'd16,   13'd64};
    phase_cfg[2] = cfg_t'{16'd65535, 16'd65535, 11'd0,    13'd0};
    phase_cfg[3] = cfg_t'{16'd0,     16'd0,     11'd1024, 13'd4096};
    phase_cfg[4] = cfg_t'{16'd2000,  16'd500,   11'd1024, 13'd100};
    // large minimum drives the loan to its ceiling, the next phase drops the loan limit under it
    phase_cfg[5] = cfg_t'{16'd65535, 16'd65535, 11'd2047, 13'd10};
    phase_cfg[6] = cfg_t'{16'd50,    16'd65535, 11'd1,    13'd30};
    phase_cfg[7] = cfg_t'{16'd1000,  16'd65535, 11'd0,    13'd8191};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed items at reset values
    send_req(make_req(OP_ACQUIRE, 0, 0, 0));
    send_req(make_req(OP_ACQUIRE, 0, 1, 1));
    send_req(make_req(OP_ACQUIRE, 0, 63, 0));
    send_req(make_req(OP_ACQUIRE, 63, 255, 255));
    send_req(make_req(OP_ACQUIRE, 63, 128, 128));
    send_req(make_req(OP_RETURN, 63, 255, 255));
    send_req(make_req(OP_RETURN, 63, 255, 0));
    send_req(make_req(OP_RETURN, 63, 3, 0));
    send_req(make_req(OP_RETURN, 1, 255, 0));
    send_req(make_req(OP_RETURN, 1, 255, 0));
    send_req(make_req(OP_RETURN, 1, 3, 0));
    send_req(make_req(OP_ACQUIRE, 1, 64, 1));
    send_req(make_req(OP_RETURN, 0, 0, 0));
    send_req(make_req(OP_ACQUIRE, 42, 170, 85));
    send_req(make_req(OP_ACQUIRE, 21, 85, 170));

    // threshold denial once anything is on loan
    drain();
    write_reg(REG_NEW_EVT_THR, 32'd0);
    send_req(make_req(OP_ACQUIRE, 2, 10, 0));
    send_req(make_req(OP_ACQUIRE, 3, 10, 1));
    send_req(make_req(OP_ACQUIRE, 3, 10, 0));
    send_req(make_req(OP_RETURN, 3, 20, 7));

    // pool limit lowered under the current loan
    drain();
    write_reg(REG_LOAN_LIMIT, 32'd100);
    send_req(make_req(OP_ACQUIRE, 4, 1, 0));
    send_req(make_req(OP_ACQUIRE, 2, 54, 0));
    send_req(make_req(OP_ACQUIRE, 2, 1, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_LOAN_LIMIT, 32'(phase_cfg[ph].loan_limit));
      write_reg(REG_NEW_EVT_THR, 32'(phase_cfg[ph].new_evt_thr));
      write_reg(REG_PORT_MIN, 32'(phase_cfg[ph].port_min_credits));
      write_reg(REG_PORT_MAX, 32'(phase_cfg[ph].port_max_credits));
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) == 0) drain();
        send_req(random_req());
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ecpc_pkg.sv
hdl/ecpc_cfg_regs.sv
hdl/ecpc_cache_mem.sv
hdl/ecpc_core.sv
hdl/event_credit_pool_controller.sv
test/ecpc_checker.sv
test/event_credit_pool_controller_tb.sv
